### rtl/gn4_pkg.sv
// shared constants and functions for the 4d gradient noise block
package gn4_pkg;

	localparam int FracBitsDefault = 16;
	localparam int CoordWidth = 32;
	localparam int OutWidth = 19;
	localparam int CellBits = 8;
	localparam int QueueDepthDefault = 4;

	// permutation rom lookup
	function automatic logic [7:0] perm(input logic [7:0] idx);
		logic [7:0] rom [256];
		rom = '{
			8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
			8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
			8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
			8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
			8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
			8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
			8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
			8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
			8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
			8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
			8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
			8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
			8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
			8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
			8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
			8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
			8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
			8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
			8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
			8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
			8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
			8'd215,8'd61,8'd156,8'd180};
		return rom[idx];
	endfunction

endpackage

### rtl/gn4_fifo.sv
// small register queue, used between front and back ends and as the output queue
module gn4_fifo #(
	parameter int Width = 8,
	parameter int Depth = gn4_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             empty
);
	localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

	logic [Width-1:0] mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (Aw+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### rtl/gn4_front.sv
// front end: splits coordinates, hashes the 16 corners, computes fade weights
module gn4_front #(
	parameter int FracBits = gn4_pkg::FracBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic signed [31:0]  cx,
	input  logic signed [31:0]  cy,
	input  logic signed [31:0]  cz,
	input  logic signed [31:0]  cw,
	output logic                out_vld,
	output logic [FracBits-1:0] frac_o [4],
	output logic [FracBits:0]   wt_o [4],
	output logic [4:0]          hash_o [16]
);
	localparam int Fw = FracBits + 1;
	localparam int Pw = 2 * Fw;
	localparam logic [Fw+3:0] Fif = (Fw+4)'(15) << FracBits;
	localparam logic [Fw+3:0] Ten = (Fw+4)'(10) << FracBits;

	// pipeline valid bits
	logic [5:0] v_q;

	logic [7:0] cell_s1 [4];
	logic [FracBits-1:0] f_s1 [4], f_s2 [4], f_s3 [4], f_s4 [4], f_s5 [4], f_s6 [4];
	logic [7:0] h1_s2 [2], h2_s3 [4], h3_s4 [8];
	logic [7:0] h4_s5 [16];
	logic [4:0] h_s6 [16];
	logic [7:0] cz_s2, cw_s2, cw_s3, cz_d, cw_d;
	logic [Fw-1:0] t2_s2 [4], t3_s3 [4];
	logic [Fw+3:0] in_s2 [4], in_s3 [4];
	logic [Fw-1:0] wt_s4 [4], wt_s5 [4], wt_s6 [4];
	logic [7:0] cy_s1_dummy;
	logic [7:0] cy_d;

	assign cy_s1_dummy = cell_s1[1];
	assign out_vld = v_q[5];

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[4:0], in_vld};
	end

	// stage 1: split; stage 2..5: hash chain; fade alongside
	always_ff @(posedge clk) begin
		logic [Pw-1:0] p;
		logic signed [Fw+4:0] lin;
		logic signed [2*Fw+8:0] pp;
		if (adv) begin
			cell_s1[0] <= cx[FracBits +: 8];
			cell_s1[1] <= cy[FracBits +: 8];
			cell_s1[2] <= cz[FracBits +: 8];
			cell_s1[3] <= cw[FracBits +: 8];
			f_s1[0] <= cx[FracBits-1:0];
			f_s1[1] <= cy[FracBits-1:0];
			f_s1[2] <= cz[FracBits-1:0];
			f_s1[3] <= cw[FracBits-1:0];
			// x hashes
			for (int b = 0; b < 2; b++)
				h1_s2[b] <= gn4_pkg::perm(cell_s1[0] + 8'(b));
			cz_s2 <= cell_s1[2];
			cw_s2 <= cell_s1[3];
			for (int k = 0; k < 4; k++) begin
				p = Pw'(f_s1[k]) * Pw'(f_s1[k]);
				t2_s2[k] <= Fw'(p >> FracBits);
				lin = (Fw+5)'(6) * $signed({5'b0, f_s1[k]}) - $signed({1'b0, Fif});
				pp = $signed({{(Fw+4){1'b0}}, f_s1[k]}) * lin;
				if (pp < 0) in_s2[k] <= Ten - (Fw+4)'((-pp) >>> FracBits);
				else in_s2[k] <= Ten + (Fw+4)'(pp >>> FracBits);
			end
			// y hashes
			for (int c = 0; c < 4; c++)
				h2_s3[c] <= gn4_pkg::perm(h1_s2[c%2] + cy_d + 8'(c/2));
			cw_s3 <= cw_s2;
			cz_d <= cz_s2;
			for (int k = 0; k < 4; k++) begin
				p = Pw'(t2_s2[k]) * Pw'(f_s2[k]);
				t3_s3[k] <= Fw'(p >> FracBits);
				in_s3[k] <= in_s2[k];
			end
			// z hashes
			for (int c = 0; c < 8; c++)
				h3_s4[c] <= gn4_pkg::perm(h2_s3[c%4] + cz_d + 8'(c/4));
			cw_d <= cw_s3;
			for (int k = 0; k < 4; k++) begin
				pp = $signed({{(Fw+4){1'b0}}, t3_s3[k]}) * $signed({1'b0, in_s3[k]});
				wt_s4[k] <= Fw'(pp >>> FracBits);
			end
			// w hashes
			for (int c = 0; c < 16; c++)
				h4_s5[c] <= gn4_pkg::perm(h3_s4[c%8] + cw_d + 8'(c/8));
			for (int c = 0; c < 16; c++) h_s6[c] <= h4_s5[c][4:0];
			for (int k = 0; k < 4; k++) begin
				f_s2[k] <= f_s1[k]; f_s3[k] <= f_s2[k]; f_s4[k] <= f_s3[k];
				f_s5[k] <= f_s4[k]; f_s6[k] <= f_s5[k];
				wt_s5[k] <= wt_s4[k]; wt_s6[k] <= wt_s5[k];
			end
		end
	end

	// y cell delay to line up with the first hash stage
	always_ff @(posedge clk) begin
		if (adv) cy_d <= cy_s1_dummy;
	end

	assign frac_o = f_s6;
	assign wt_o = wt_s6;
	assign hash_o = h_s6;
endmodule

### rtl/gn4_back.sv
// back end: corner gradients and the four levels of interpolation
module gn4_back #(
	parameter int FracBits = gn4_pkg::FracBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic [FracBits-1:0] frac_i [4],
	input  logic [FracBits:0]   wt_i [4],
	input  logic [4:0]          hash_i [16],
	output logic                out_vld,
	output logic signed [gn4_pkg::OutWidth-1:0] noise_o
);
	localparam int Vw = FracBits + 4;
	localparam int Fw = FracBits + 1;
	localparam logic signed [Vw-1:0] One = Vw'(1) << FracBits;
	localparam logic signed [Vw-1:0] Lim = Vw'(3) << FracBits;
	localparam int Ow = gn4_pkg::OutWidth;

	logic [5:0] v_q;
	logic signed [Vw-1:0] g_s1 [16], l1_s2 [8], l2_s3 [4], l3_s4 [2], l4_s5;
	logic [Fw-1:0] w_s1 [4], w_s2 [4], w_s3 [4], w_s4 [4];
	logic signed [Ow-1:0] o_s6;

	assign out_vld = v_q[5];
	assign noise_o = o_s6;

	// one interpolation with truncating product
	function automatic logic signed [Vw-1:0] lerp(input logic [Fw-1:0] s,
		input logic signed [Vw-1:0] a, input logic signed [Vw-1:0] b);
		logic signed [Vw:0] d;
		logic signed [Vw+Fw+1:0] p;
		logic signed [Vw+Fw+1:0] q;
		d = (Vw+1)'(b) - (Vw+1)'(a);
		p = $signed({1'b0, s}) * d;
		q = (p < 0) ? -((-p) >>> FracBits) : (p >>> FracBits);
		return a + Vw'(q);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[4:0], in_vld};
	end

	// gradients, then one lerp level per stage
	always_ff @(posedge clk) begin
		logic signed [Vw-1:0] off [4];
		logic signed [Vw-1:0] a, b, c, r;
		if (adv) begin
			for (int k = 0; k < 16; k++) begin
				for (int ax = 0; ax < 4; ax++)
					off[ax] = k[ax] ? $signed(Vw'(frac_i[ax])) - One
						: $signed(Vw'(frac_i[ax]));
				case (hash_i[k][4:3])
					2'd1: begin a = off[3]; b = off[0]; c = off[1]; end
					2'd2: begin a = off[2]; b = off[3]; c = off[0]; end
					default: begin a = off[1]; b = off[2]; c = off[3]; end
				endcase
				g_s1[k] <= (hash_i[k][2] ? a : -a) + (hash_i[k][1] ? b : -b)
					+ (hash_i[k][0] ? c : -c);
			end
			w_s1 <= wt_i;
			for (int k = 0; k < 8; k++) l1_s2[k] <= lerp(w_s1[0], g_s1[2*k], g_s1[2*k+1]);
			w_s2 <= w_s1;
			for (int k = 0; k < 4; k++) l2_s3[k] <= lerp(w_s2[1], l1_s2[2*k], l1_s2[2*k+1]);
			w_s3 <= w_s2;
			for (int k = 0; k < 2; k++) l3_s4[k] <= lerp(w_s3[2], l2_s3[2*k], l2_s3[2*k+1]);
			w_s4 <= w_s3;
			l4_s5 <= lerp(w_s4[3], l3_s4[0], l3_s4[1]);
			r = l4_s5;
			if (r > Lim) r = Lim;
			if (r < -Lim) r = -Lim;
			if (Vw > Ow) begin
				if (r > $signed(Vw'((1 << (Ow-1)) - 1))) r = Vw'((1 << (Ow-1)) - 1);
				if (r < -$signed(Vw'(1 << (Ow-1)))) r = -$signed(Vw'(1 << (Ow-1)));
			end
			o_s6 <= Ow'(r);
		end
	end
endmodule

### rtl/gradient_noise_4d.sv
// top level of the 4d gradient noise block
//  channel | signals                                   | accepted when
//  input   | push full coord_x coord_y coord_z coord_w | push && !full
//  result  | empty pop noise_value                     | pop && !empty
// one item per cycle while the front end does not stall; a result passes through:
// six front stages, the middle queue, six back stages and the output queue
// reset clears only valid bits and queue pointers and counts
// each pipeline advances unless its last stage holds an item the queue ahead
// of it cannot take, so each side stalls on its own; the output queue lets
// input continue while results wait
module gradient_noise_4d #(
	parameter int FracBits = gn4_pkg::FracBitsDefault,
	parameter int QueueDepth = gn4_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] coord_w,
	output logic        empty,
	input  logic        pop,
	output logic signed [gn4_pkg::OutWidth-1:0] noise_value
);
	localparam int Ow = gn4_pkg::OutWidth;
	localparam int Mw = 4 * FracBits + 4 * (FracBits + 1) + 80;

	logic fe_adv, fe_vld, be_adv, be_vld, mq_full, mq_empty, mq_pop, oq_full;
	logic in_acc, mq_push, oq_push;
	logic [FracBits-1:0] fr [4], fr_q [4];
	logic [FracBits:0] wt [4], wt_qd [4];
	logic [4:0] hs [16], hs_q [16];
	logic [Mw-1:0] mq_in, mq_out;
	logic signed [Ow-1:0] nv;

	// front stalls while its last stage holds an item the middle queue cannot take
	assign fe_adv = !(fe_vld && mq_full);
	assign full = !fe_adv;
	assign in_acc = push && fe_adv;
	assign mq_push = fe_vld && fe_adv;

	gn4_front #(.FracBits(FracBits)) u_front (
		.clk, .arst_n, .adv(fe_adv), .in_vld(in_acc),
		.cx(coord_x), .cy(coord_y), .cz(coord_z), .cw(coord_w),
		.out_vld(fe_vld), .frac_o(fr), .wt_o(wt), .hash_o(hs));

	// pack and unpack middle queue payload
	always_comb begin
		mq_in = '0;
		for (int k = 0; k < 4; k++) begin
			mq_in[k*FracBits +: FracBits] = fr[k];
			mq_in[4*FracBits + k*(FracBits+1) +: FracBits+1] = wt[k];
		end
		for (int k = 0; k < 16; k++) mq_in[8*FracBits + 4 + k*5 +: 5] = hs[k];
		for (int k = 0; k < 4; k++) begin
			fr_q[k] = mq_out[k*FracBits +: FracBits];
			wt_qd[k] = mq_out[4*FracBits + k*(FracBits+1) +: FracBits+1];
		end
		for (int k = 0; k < 16; k++) hs_q[k] = mq_out[8*FracBits + 4 + k*5 +: 5];
	end

	gn4_fifo #(.Width(Mw), .Depth(QueueDepth)) u_mq (
		.clk, .arst_n, .wr_en(mq_push), .wr_data(mq_in), .full(mq_full),
		.rd_en(mq_pop), .rd_data(mq_out), .empty(mq_empty));

	// back stalls while its last stage holds an item the output queue cannot take
	assign be_adv = !(be_vld && oq_full);
	assign mq_pop = !mq_empty && be_adv;
	assign oq_push = be_vld && be_adv;
	gn4_back #(.FracBits(FracBits)) u_back (
		.clk, .arst_n, .adv(be_adv), .in_vld(mq_pop),
		.frac_i(fr_q), .wt_i(wt_qd), .hash_i(hs_q), .out_vld(be_vld), .noise_o(nv));

	gn4_fifo #(.Width(Ow), .Depth(QueueDepth)) u_oq (
		.clk, .arst_n, .wr_en(oq_push), .wr_data(nv), .full(oq_full),
		.rd_en(pop), .rd_data(noise_value), .empty(empty));
endmodule

### dv/gradient_noise_4d_tb.sv
// testbench for the 4d gradient noise block: queue-fed driver, monitor and noise predictor
`timescale 1ns / 1ps

module gradient_noise_4d_tb;

	localparam int FracBits = 16;
	localparam longint FixOne = longint'(1) << FracBits;
	localparam int StallLimit = 4000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
	} point_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [31:0] coord_x, coord_y, coord_z, coord_w;
	logic empty;
	logic pop;
	logic signed [gn4_pkg::OutWidth-1:0] noise_value;

	gradient_noise_4d u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .coord_w(coord_w),
		.empty(empty), .pop(pop), .noise_value(noise_value)
	);

	point_t pending_points[$];
	logic [gn4_pkg::OutWidth-1:0] expected_noise[$];
	byte unsigned shuffle_rom[256];
	int mismatch_count;
	int send_idle_pct, recv_idle_pct;
	int hold_cycles;
	int quiet_cycles;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// truncating fixed-point product
	function automatic longint fix_mul(longint a, longint b);
		longint p;
		p = a * b;
		if (p < 0)
			return -((-p) >>> FracBits);
		return p >>> FracBits;
	endfunction

	function automatic longint smooth_weight(longint t);
		longint t2, t3, inner;
		t2 = fix_mul(t, t);
		t3 = fix_mul(t2, t);
		inner = fix_mul(t, 6 * t - 15 * FixOne) + 10 * FixOne;
		return fix_mul(t3, inner);
	endfunction

	function automatic longint corner_dot(int h, longint ox, longint oy, longint oz,
			longint ow);
		longint a, b, c;
		a = oy; b = oz; c = ow;
		case (h[4:3])
			2'd1: begin a = ow; b = ox; c = oy; end
			2'd2: begin a = oz; b = ow; c = ox; end
			default: ;
		endcase
		return (h[2] ? a : -a) + (h[1] ? b : -b) + (h[0] ? c : -c);
	endfunction

	// noise value for one point
	function automatic logic [gn4_pkg::OutWidth-1:0] noise_of(point_t p);
		logic [31:0] raw[4];
		int cellv[4];
		longint fr[4], wt[4], acc[16], off[4], r, sv;
		int h, n, bitv;
		raw[0] = p.x; raw[1] = p.y; raw[2] = p.z; raw[3] = p.w;
		for (int a = 0; a < 4; a++) begin
			sv = longint'(signed'(raw[a]));
			fr[a] = longint'(raw[a][FracBits-1:0]);
			cellv[a] = int'(((sv - fr[a]) / FixOne) & 255);
			wt[a] = smooth_weight(fr[a]);
		end
		for (int c = 0; c < 16; c++) begin
			h = 0;
			for (int a = 0; a < 4; a++) begin
				bitv = (c >> a) & 1;
				h = shuffle_rom[(h + cellv[a] + bitv) & 255];
				off[a] = bitv ? fr[a] - FixOne : fr[a];
			end
			acc[c] = corner_dot(h & 31, off[0], off[1], off[2], off[3]);
		end
		n = 16;
		for (int a = 0; a < 4; a++) begin
			n = n >> 1;
			for (int k = 0; k < n; k++)
				acc[k] = acc[2*k] + fix_mul(wt[a], acc[2*k+1] - acc[2*k]);
		end
		r = acc[0];
		if (r > 3 * FixOne) r = 3 * FixOne;
		if (r < -3 * FixOne) r = -3 * FixOne;
		if (r > 262143) r = 262143;
		if (r < -262144) r = -262144;
		return r[gn4_pkg::OutWidth-1:0];
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("noise mismatch (%s): got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			2: return {16'($urandom_range(0, 600) - 300), 16'($urandom())};
			3: return {16'($urandom()), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
			default: return {16'($urandom_range(0, 8) - 4), 16'($urandom())};
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			coord_x <= '0; coord_y <= '0; coord_z <= '0; coord_w <= '0;
		end else begin
			if (push && !full)
				void'(pending_points.pop_front());
			if (pending_points.size() > (push && !full ? 0 : 0) &&
					!(push && !full && pending_points.size() == 0) &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				push <= 1'b1;
				coord_x <= pending_points[0].x;
				coord_y <= pending_points[0].y;
				coord_z <= pending_points[0].z;
				coord_w <= pending_points[0].w;
			end else if (!(push && full)) begin
				push <= 1'b0;
			end
		end
	end

	// prediction on acceptance
	always @(posedge clk) begin
		if (arst_n && push && !full)
			expected_noise.push_back(noise_of(point_t'({coord_x, coord_y, coord_z, coord_w})));
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		logic [gn4_pkg::OutWidth-1:0] want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_noise.size() == 0) begin
					report_mismatch("unexpected", 32'(noise_value), 32'h0);
				end else begin
					want = expected_noise.pop_front();
					if (noise_value !== want)
						report_mismatch("noise_value", 32'(noise_value), 32'(want));
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		point_t p;
		logic [31:0] edges[8];
		for (int i = 0; i < 256; i++)
			shuffle_rom[i] = gn4_pkg::perm(8'(i));
		mismatch_count = 0;
		send_idle_pct = 19;
		recv_idle_pct = 77;
		hold_cycles = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed corners: extremes, cell wrap, negative coordinates
		edges = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_FFFF, 32'h0001_0000, 32'hFF00_8000, 32'h0100_0000};
		for (int i = 0; i < 8; i++) begin
			p = '{edges[i], edges[(i + 1) % 8], edges[(i + 3) % 8], edges[(i + 5) % 8]};
			pending_points.push_back(p);
		end
		for (int i = 0; i < 8; i++)
			pending_points.push_back('{edges[i], edges[i], edges[i], edges[i]});
		pending_points.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA});
		pending_points.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555});

		// three idling phases of random points
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle_pct = 77; recv_idle_pct = 19; end
			if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
			for (int i = 0; i < 650; i++)
				pending_points.push_back('{rand_coord(), rand_coord(), rand_coord(),
					rand_coord()});
			if (ph == 2) hold_cycles = 300;
			wait (pending_points.size() == 0);
		end
		// let the last accepted item reach the prediction queue
		@(posedge clk);
		wait (expected_noise.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && expected_noise.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
